>>> src/tlbpt_pkg.sv
`timescale 1ns / 1ps

package tlbpt_pkg;

	// address and counter widths fixed by the stream format
	localparam int unsigned VA_W = 16;
	localparam int unsigned CNT_W = 32;

	// result beat layout, lowest bit first
	localparam int unsigned PA_LSB = 0;
	localparam int unsigned ACC_LSB = PA_LSB + VA_W;
	localparam int unsigned HIT_LSB = ACC_LSB + CNT_W;
	localparam int unsigned FLT_LSB = HIT_LSB + CNT_W;
	localparam int unsigned M_TDATA_W = FLT_LSB + CNT_W;

	localparam int unsigned TUSER_HIT = 0;
	localparam int unsigned TUSER_FAULT = 1;
	localparam int unsigned M_TUSER_W = 2;

	typedef logic [VA_W-1:0] va_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

>>> src/tlbpt_page_table.sv
`timescale 1ns / 1ps

module tlbpt_page_table #(
	parameter int unsigned PAGE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [PAGE_BITS-1:0] rd_addr,
	output logic                 rd_valid,
	output logic [PAGE_BITS-1:0] rd_frame,
	input  logic                 wr_en,
	input  logic [PAGE_BITS-1:0] wr_addr,
	input  logic [PAGE_BITS-1:0] wr_frame,
	output logic                 busy
);

	localparam int unsigned DEPTH = 1 << PAGE_BITS;

	// each word: valid bit on top, frame below
	logic [PAGE_BITS:0] mem [DEPTH];
	logic [PAGE_BITS:0] rdata_q;
	logic               clr_busy_q;
	logic [PAGE_BITS-1:0] clr_addr_q;

	logic               we;
	logic [PAGE_BITS-1:0] waddr;
	logic [PAGE_BITS:0] wdata;

	// clearing sweep owns the write port right after reset
	always_comb begin
		if (clr_busy_q) begin
			we = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we = wr_en;
			waddr = wr_addr;
			wdata = {1'b1, wr_frame};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {PAGE_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_valid = rdata_q[PAGE_BITS];
	assign rd_frame = rdata_q[PAGE_BITS-1:0];
	assign busy = clr_busy_q;

endmodule

>>> src/tlbpt_cam.sv
`timescale 1ns / 1ps

module tlbpt_cam #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned PAGE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] lookup_page,
	output logic                 hit,
	output logic [PAGE_BITS-1:0] hit_frame,
	input  logic                 fill_en,
	input  logic [PAGE_BITS-1:0] fill_page,
	input  logic [PAGE_BITS-1:0] fill_frame
);

	localparam int unsigned PTR_W = $clog2(ENTRIES);

	logic [ENTRIES-1:0]   valid_q;
	logic [PAGE_BITS-1:0] page_q  [ENTRIES];
	logic [PAGE_BITS-1:0] frame_q [ENTRIES];
	logic [PTR_W-1:0]     ptr_q;

	// lowest matching entry wins
	always_comb begin
		hit = 1'b0;
		hit_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit && valid_q[i] && page_q[i] == lookup_page) begin
				hit = 1'b1;
				hit_frame = frame_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q <= '0;
		end else if (fill_en) begin
			valid_q[ptr_q] <= 1'b1;
			if (ptr_q == PTR_W'(ENTRIES - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_en) begin
			page_q[ptr_q] <= fill_page;
			frame_q[ptr_q] <= fill_frame;
		end
	end

endmodule

>>> src/tlb_page_translation.sv
`timescale 1ns / 1ps

// Translates 16-bit virtual addresses to physical addresses. The page number
// (PAGE_BITS above the low OFFSET_BITS) is compared against every entry of a
// fully associative TLB of TLB_ENTRIES entries; on a miss a page table memory
// indexed by page number supplies the frame and the mapping is loaded into the
// TLB at a round-robin (FIFO) slot. An unmapped page takes the next free frame
// in order, is written into both the table and the TLB and counts as a fault.
// Each result beat carries the physical address, hit and fault flags and
// three wrapping 32-bit counters (accesses, TLB hits, faults). The page table
// read is issued on the accept edge; TLB compare, refill and table write-back
// follow once the output register is free. s_tready stays low while an address
// is in the lookup stage, so the next is taken only once that one has left. The
// result sits in an output register, so a new address may be taken while the
// previous result waits on m_tready. After reset the page table is cleared one
// entry per cycle, all 2**PAGE_BITS (256 by default), with s_tready held low.

module tlb_page_translation #(
	parameter int unsigned TLB_ENTRIES = 16,
	parameter int unsigned OFFSET_BITS = 8,
	parameter int unsigned PAGE_BITS   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tlbpt_pkg::VA_W-1:0]       s_tdata,  // virtual_address
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// physical_address, access_count, hit_count, fault_count
	output logic [tlbpt_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [tlbpt_pkg::M_TUSER_W-1:0]  m_tuser   // tlb_hit, page_fault
);

	localparam int unsigned VA_W = tlbpt_pkg::VA_W;
	localparam logic [VA_W-1:0] OFF_MASK = VA_W'((32'd1 << OFFSET_BITS) - 32'd1);
	localparam logic [PAGE_BITS:0] PAGE_COUNT = (PAGE_BITS+1)'(1) << PAGE_BITS;

	// split of the incoming beat
	logic [2*VA_W-1:0]    va_ext;
	logic [PAGE_BITS-1:0] page_in;
	logic                 accept;

	// lookup stage
	logic                 s1_valid_q;
	logic [PAGE_BITS-1:0] page_s1;
	logic [VA_W-1:0]      offset_s1;

	// page table and TLB
	logic                 clr_busy;
	logic                 tbl_valid;
	logic [PAGE_BITS-1:0] tbl_frame;
	logic                 tlb_hit_now;
	logic [PAGE_BITS-1:0] tlb_frame;

	logic                 fault_now;
	logic [PAGE_BITS-1:0] frame_now;
	logic [31:0]          frame_sh;
	logic                 out_free;
	logic                 done;

	logic [PAGE_BITS:0]   next_frame_q;
	tlbpt_pkg::cnt_t      access_q;
	tlbpt_pkg::cnt_t      hits_q;
	tlbpt_pkg::cnt_t      faults_q;

	// output register
	logic                 m_valid_q;
	tlbpt_pkg::va_t       pa_q;
	logic                 hit_q;
	logic                 fault_q;

	assign va_ext = {{VA_W{1'b0}}, s_tdata};
	assign page_in = va_ext[OFFSET_BITS +: PAGE_BITS];

	// one address in flight through the lookup stage at a time
	assign s_tready = !clr_busy && !s1_valid_q;
	assign accept = s_tvalid && s_tready;

	assign out_free = !m_valid_q || m_tready;
	assign done = s1_valid_q && out_free;

	tlbpt_page_table #(
		.PAGE_BITS(PAGE_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (page_in),
		.rd_valid(tbl_valid),
		.rd_frame(tbl_frame),
		.wr_en   (done && fault_now),
		.wr_addr (page_s1),
		.wr_frame(frame_now),
		.busy    (clr_busy)
	);

	tlbpt_cam #(
		.ENTRIES  (TLB_ENTRIES),
		.PAGE_BITS(PAGE_BITS)
	) u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_page(page_s1),
		.hit        (tlb_hit_now),
		.hit_frame  (tlb_frame),
		.fill_en    (done && !tlb_hit_now),
		.fill_page  (page_s1),
		.fill_frame (frame_now)
	);

	// tlb first, then the table, else a fresh frame
	assign fault_now = !tlb_hit_now && !tbl_valid;

	always_comb begin
		if (tlb_hit_now) begin
			frame_now = tlb_frame;
		end else if (tbl_valid) begin
			frame_now = tbl_frame;
		end else begin
			frame_now = next_frame_q[PAGE_BITS-1:0];
		end
	end

	assign frame_sh = 32'(frame_now) << OFFSET_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q <= 1'b0;
			next_frame_q <= '0;
			access_q <= '0;
			hits_q <= '0;
			faults_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end

			if (done) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			if (done) begin
				access_q <= access_q + 1'b1;
				if (tlb_hit_now) begin
					hits_q <= hits_q + 1'b1;
				end
				if (fault_now) begin
					faults_q <= faults_q + 1'b1;
					// once all frames are handed out, stop at the page count; frame 0 is then given
					if (!next_frame_q[PAGE_BITS]) begin
						next_frame_q <= next_frame_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= page_in;
			offset_s1 <= s_tdata & OFF_MASK;
		end
		if (done) begin
			pa_q <= frame_sh[VA_W-1:0] | offset_s1;
			hit_q <= tlb_hit_now;
			fault_q <= fault_now;
		end
	end

	// counters only move when a new result is loaded, so they sit in the beat
	assign m_tvalid = m_valid_q;
	assign m_tdata = {faults_q, hits_q, access_q, pa_q};
	assign m_tuser = {fault_q, hit_q};

`ifndef NO_ASSERTIONS
	a_hit_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(hit_q && fault_q))
		else $error("tlb hit and page fault on the same beat");

	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted beat did not enter lookup");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("beat taken while page table is clearing");

	a_access_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> access_q == $past(access_q) + 32'd1)
		else $error("access counter did not advance on completion");

	a_fault_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fault_now) |=> faults_q == $past(faults_q) + 32'd1)
		else $error("fault counter did not advance on page fault");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_frame_q <= PAGE_COUNT)
		else $error("free frame counter beyond page count");
`endif

endmodule

>>> tb/tb_tlb_page_translation.sv
`timescale 1ns / 1ps

module tb_tlb_page_translation;

	// block configuration, kept at the defaults
	localparam int unsigned TLB_ENTRIES = 16;
	localparam int unsigned OFFSET_BITS = 8;
	localparam int unsigned PAGE_BITS   = 8;
	localparam int unsigned PAGE_COUNT  = 1 << PAGE_BITS;

	// cycles allowed after the last result before the verdict
	localparam int unsigned SETTLE_CYCLES = 16;

	// one translated beat as the block should return it
	typedef struct {
		tlbpt_pkg::va_t  physical_address;
		logic            tlb_hit;
		logic            page_fault;
		tlbpt_pkg::cnt_t access_count;
		tlbpt_pkg::cnt_t hit_count;
		tlbpt_pkg::cnt_t fault_count;
	} translation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	tlbpt_pkg::va_t                  s_tdata = '0;     // virtual_address
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// physical_address, access_count, hit_count, fault_count
	logic [tlbpt_pkg::M_TDATA_W-1:0] m_tdata;
	logic [tlbpt_pkg::M_TUSER_W-1:0] m_tuser;          // tlb_hit, page_fault

	tlb_page_translation #(
		.TLB_ENTRIES(TLB_ENTRIES),
		.OFFSET_BITS(OFFSET_BITS),
		.PAGE_BITS  (PAGE_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// translation predictor: its own copy of tlb, page table and counters
	// ------------------------------------------------------------------
	logic                 tlb_used [TLB_ENTRIES];
	logic [PAGE_BITS-1:0] tlb_vpn  [TLB_ENTRIES];
	logic [PAGE_BITS-1:0] tlb_pfn  [TLB_ENTRIES];
	int unsigned          refill_slot;
	logic                 page_mapped [PAGE_COUNT];
	logic [PAGE_BITS-1:0] page_frame  [PAGE_COUNT];
	int unsigned          free_frame;
	tlbpt_pkg::cnt_t      accesses_so_far;
	tlbpt_pkg::cnt_t      hits_so_far;
	tlbpt_pkg::cnt_t      faults_so_far;

	translation_t expected_translations[$];

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;

	function automatic void clear_translation_state();
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			tlb_used[i] = 1'b0;
			tlb_vpn[i] = '0;
			tlb_pfn[i] = '0;
		end
		for (int p = 0; p < PAGE_COUNT; p++) begin
			page_mapped[p] = 1'b0;
			page_frame[p] = '0;
		end
		refill_slot = 0;
		free_frame = 0;
		accesses_so_far = '0;
		hits_so_far = '0;
		faults_so_far = '0;
	endfunction

	function automatic void load_tlb(logic [PAGE_BITS-1:0] vpn, logic [PAGE_BITS-1:0] pfn);
		tlb_used[refill_slot] = 1'b1;
		tlb_vpn[refill_slot] = vpn;
		tlb_pfn[refill_slot] = pfn;
		refill_slot = (refill_slot + 1) % TLB_ENTRIES;
	endfunction

	function automatic translation_t translate_address(tlbpt_pkg::va_t va);
		translation_t         t;
		logic [PAGE_BITS-1:0] vpn;
		logic [PAGE_BITS-1:0] pfn;
		logic                 found;
		vpn = va[OFFSET_BITS +: PAGE_BITS];
		pfn = '0;
		found = 1'b0;
		accesses_so_far = accesses_so_far + 1;
		// lowest matching slot wins, though a page is never in two slots
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!found && tlb_used[i] && tlb_vpn[i] == vpn) begin
				found = 1'b1;
				pfn = tlb_pfn[i];
			end
		end
		t.tlb_hit = found;
		t.page_fault = 1'b0;
		if (found) begin
			hits_so_far = hits_so_far + 1;
		end else if (page_mapped[vpn]) begin
			// page table hit, refill the tlb
			pfn = page_frame[vpn];
			load_tlb(vpn, pfn);
		end else begin
			// demand paging: frames in order, then frame 0 once all are used
			t.page_fault = 1'b1;
			faults_so_far = faults_so_far + 1;
			pfn = free_frame[PAGE_BITS-1:0];
			if (free_frame < PAGE_COUNT)
				free_frame++;
			page_mapped[vpn] = 1'b1;
			page_frame[vpn] = pfn;
			load_tlb(vpn, pfn);
		end
		t.physical_address = tlbpt_pkg::va_t'({pfn, va[OFFSET_BITS-1:0]});
		t.access_count = accesses_so_far;
		t.hit_count = hits_so_far;
		t.fault_count = faults_so_far;
		return t;
	endfunction

	// ------------------------------------------------------------------
	// address sender: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_address(input tlbpt_pkg::va_t va);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= va;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_translations.push_back(translate_address(va));
	endtask

	// hold the sender off until every pending result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_translations.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// result receiver: stall pattern reloaded now and then, sometimes solid
	// ------------------------------------------------------------------
	logic [15:0] stall_pattern = 16'hFFFF;
	int unsigned pattern_age = 0;

	always @(posedge clk) begin
		m_tready <= stall_pattern[15];
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern <= 16'hFFFF;
				1: stall_pattern <= 16'($urandom());
				2: stall_pattern <= 16'($urandom() & $urandom() & $urandom()) | 16'h0001;
				default: stall_pattern <= 16'($urandom() | $urandom());
			endcase
			pattern_age = $urandom_range(32, 200);
		end else begin
			stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
			pattern_age--;
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string label, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on beat %0d: %s expected 0x%0h got 0x%0h",
				         results_seen, label, want, got);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		translation_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_translations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat 0x%0h user 0x%0h", m_tdata, m_tuser);
			end else begin
				want = expected_translations.pop_front();
				check_field("physical_address", 32'(want.physical_address),
				            32'(m_tdata[tlbpt_pkg::PA_LSB +: tlbpt_pkg::VA_W]));
				check_field("tlb_hit", 32'(want.tlb_hit),
				            32'(m_tuser[tlbpt_pkg::TUSER_HIT]));
				check_field("page_fault", 32'(want.page_fault),
				            32'(m_tuser[tlbpt_pkg::TUSER_FAULT]));
				check_field("access_count", want.access_count,
				            m_tdata[tlbpt_pkg::ACC_LSB +: tlbpt_pkg::CNT_W]);
				check_field("hit_count", want.hit_count,
				            m_tdata[tlbpt_pkg::HIT_LSB +: tlbpt_pkg::CNT_W]);
				check_field("fault_count", want.fault_count,
				            m_tdata[tlbpt_pkg::FLT_LSB +: tlbpt_pkg::CNT_W]);
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// all-zero and all-one fields, both offset extremes on the same page
	task automatic test_edge_addresses();
		send_address(16'h0000);   // first fault gets frame 0
		send_address(16'h00FF);   // tlb hit, same page
		send_address(16'hFFFF);   // second fault, frame 1
		send_address(16'hFF00);   // tlb hit on top page
		send_address(16'h5AA5);
		send_address(16'hA55A);
		drain_results();
	endtask

	// wrap the refill pointer so the oldest entries go, then come back to them
	task automatic test_fifo_eviction();
		for (int p = 1; p <= 14; p++)
			send_address(tlbpt_pkg::va_t'({8'(p), 8'($urandom())}));
		// pages 0x00 and 0xff are now only in the page table
		send_address(16'h0042);
		send_address(16'hFF81);
		send_address(16'h00C3);   // back in the tlb after the refill
		drain_results();
	endtask

	// working set of varying size: hits while it fits, thrashing when it does not,
	// mixed with scattered addresses that fault early and refill later
	task automatic test_random_traffic();
		logic [PAGE_BITS-1:0] hot_pages[24];
		int unsigned          hot_size;
		logic [7:0]           offset;
		logic [PAGE_BITS-1:0] vpn;
		for (int phase = 0; phase < 7; phase++) begin
			case ($urandom_range(0, 4))
				0: hot_size = 4;
				1: hot_size = 12;
				2: hot_size = 16;
				3: hot_size = 17;
				default: hot_size = 24;
			endcase
			foreach (hot_pages[i])
				hot_pages[i] = PAGE_BITS'($urandom());
			for (int n = 0; n < 250; n++) begin
				case ($urandom_range(0, 7))
					0: offset = 8'h00;
					1: offset = 8'hFF;
					default: offset = 8'($urandom());
				endcase
				if ($urandom_range(0, 99) < 60)
					vpn = hot_pages[$urandom_range(0, hot_size - 1)];
				else
					vpn = PAGE_BITS'($urandom());
				send_address(tlbpt_pkg::va_t'({vpn, offset}));
				// drift the working set slowly
				if ($urandom_range(0, 31) == 0)
					hot_pages[$urandom_range(0, hot_size - 1)] = PAGE_BITS'($urandom());
			end
			drain_results();
		end
	endtask

	initial begin
		clear_translation_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_addresses();
		test_fifo_eviction();
		test_random_traffic();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS tlb_page_translation");
		else
			$display("FAIL tlb_page_translation");
		$finish;
	end

	// hang guard, far above the slowest legal run including the table clear
	initial begin
		#50_000_000;
		$display("FAIL tlb_page_translation");
		$finish;
	end

endmodule
